@@ sv/stbs_pkg.sv @@
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared widths, operation codes and controller/datapath interface types
// for the sorted table binary search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int OP_W    = 1;
  localparam int IDX_W   = 10;
  localparam int VALUE_W = 32;
  localparam int RANGE_W = 11;
  localparam int POS_W   = 10;

  localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
  localparam logic [OP_W-1:0] OP_SEARCH = 1'b1;

  typedef struct packed {
    logic load;
    logic wr;
    logic probe;
    logic step_lo;
    logic step_hi;
    logic done_found;
    logic done_miss;
  } stbs_cmd_t;

  typedef struct packed {
    logic nonempty;
    logic eq;
    logic lt;
  } stbs_sts_t;

endpackage

@@ sv/stbs_ram.sv @@
// ----------------------------------------------------------------------------
// stbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/stbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// stbs_ctrl
// Search sequencer: accepts items, steps the halving loop and signals the
// result cycle to the datapath.
// ----------------------------------------------------------------------------
module stbs_ctrl
  import stbs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [OP_W-1:0] op,
  input  stbs_sts_t       sts,
  output stbs_cmd_t       cmd,
  output logic            busy
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (op == OP_SEARCH) begin
            cmd.load  = 1'b1;
            state_nxt = ST_PROBE;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (sts.nonempty) begin
          cmd.probe = 1'b1;
          state_nxt = ST_CMP;
        end else begin
          cmd.done_miss = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_CMP: begin
        if (sts.eq) begin
          cmd.done_found = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (sts.lt) begin
          cmd.step_lo = 1'b1;
          state_nxt   = ST_PROBE;
        end else begin
          cmd.step_hi = 1'b1;
          state_nxt   = ST_PROBE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cmd.load && !cmd.wr)
    else $error("item taken while busy");

  a_cmp_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe |=> state_r == ST_CMP)
    else $error("compare step lost after table read");

endmodule

@@ sv/stbs_dp.sv @@
// ----------------------------------------------------------------------------
// stbs_dp
// Search datapath: table RAM, range bounds, midpoint, compare and result
// registers.
// ----------------------------------------------------------------------------
module stbs_dp
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  stbs_cmd_t                 cmd,
  input  logic [IDX_W-1:0]          in_entry_index,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [RANGE_W-1:0]        in_range_low,
  input  logic [RANGE_W-1:0]        in_range_high,
  output stbs_sts_t                 sts,
  output logic                      out_valid,
  output logic                      out_found,
  output logic [POS_W-1:0]          out_position
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = AW + 1;

  logic [IW-1:0]             lo_r;
  logic [IW-1:0]             hi_r;
  logic [AW-1:0]             mid_r;
  logic signed [VALUE_W-1:0] target_r;
  logic                      out_valid_r;
  logic                      out_found_r;
  logic [POS_W-1:0]          out_position_r;

  logic [IW:0]               sum;
  logic [AW-1:0]             mid_w;
  logic                      wr_en;
  logic [VALUE_W-1:0]        rdata;

  function automatic logic [IW-1:0] clamp(input logic [RANGE_W-1:0] x);
    if (32'(x) > TABLE_DEPTH) begin
      return IW'(TABLE_DEPTH);
    end
    return IW'(32'(x));
  endfunction

  assign sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_w = sum[AW:1];
  assign wr_en = cmd.wr && (32'(in_entry_index) < TABLE_DEPTH);

  stbs_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(AW'(32'(in_entry_index))),
    .wdata(in_value),
    .re   (cmd.probe),
    .raddr(mid_w),
    .rdata(rdata)
  );

  assign sts.nonempty = (lo_r < hi_r);
  assign sts.eq       = ($signed(rdata) == target_r);
  assign sts.lt       = ($signed(rdata) < target_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_r     <= clamp(in_range_low);
      hi_r     <= clamp(in_range_high);
      target_r <= in_value;
    end
    if (cmd.probe) begin
      mid_r <= mid_w;
    end
    if (cmd.step_lo) begin
      lo_r <= IW'(mid_r) + IW'(1);
    end
    if (cmd.step_hi) begin
      hi_r <= IW'(mid_r);
    end
    if (cmd.done_found) begin
      out_found_r    <= 1'b1;
      out_position_r <= POS_W'(32'(mid_r));
    end else if (cmd.done_miss) begin
      out_found_r    <= 1'b0;
      out_position_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.done_found || cmd.done_miss;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

  a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_position_r == '0)
    else $error("miss reported with non-zero position");

  a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe |=> (IW'(mid_r) >= lo_r) && (IW'(mid_r) < hi_r))
    else $error("midpoint outside search range");

  a_hi_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe |-> hi_r <= IW'(TABLE_DEPTH))
    else $error("upper bound beyond table");

endmodule

@@ sv/sorted_table_binary_search.sv @@
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Table of signed entries with a binary search over a half-open index range.
// Write item: no result. Search item: each halving step is one registered
// table read followed by one compare. For a search, busy stays high from
// acceptance until the result strobe; the result is shown on out_valid for
// one cycle and cannot be held off. Reset clears the controller and the
// strobe; table contents are undefined until written.
// ----------------------------------------------------------------------------
module sorted_table_binary_search
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [OP_W-1:0]           in_op,
  input  logic [IDX_W-1:0]          in_entry_index,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [RANGE_W-1:0]        in_range_low,
  input  logic [RANGE_W-1:0]        in_range_high,
  output logic                      out_valid,
  output logic                      out_found,
  output logic [POS_W-1:0]          out_position
);

  stbs_cmd_t cmd;
  stbs_sts_t sts;

  stbs_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .op   (in_op),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  stbs_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_entry_index(in_entry_index),
    .in_value      (in_value),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_found     (out_found),
    .out_position  (out_position)
  );

endmodule

@@ sim/sorted_table_binary_search_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_checker
// Watches the item and result channels of the sorted table search block,
// keeps its own copy of the table from accepted writes, predicts the outcome
// of every accepted search and compares each result strobe against the
// oldest prediction. Reports the number of mismatches and of results still
// awaited.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_checker
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [OP_W-1:0]           in_op,
  input  logic [IDX_W-1:0]          in_entry_index,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [RANGE_W-1:0]        in_range_low,
  input  logic [RANGE_W-1:0]        in_range_high,
  input  logic                      out_valid,
  input  logic                      out_found,
  input  logic [POS_W-1:0]          out_position,
  output int                        fail_count,
  output int                        outstanding
);

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } search_outcome_t;

  logic signed [VALUE_W-1:0] entry_copy [TABLE_DEPTH];
  search_outcome_t           awaited_outcomes [$];
  int                        mismatches = 0;
  int                        awaited_count = 0;

  assign fail_count  = mismatches;
  assign outstanding = awaited_count;

  function automatic search_outcome_t search_table(
    input logic signed [VALUE_W-1:0] target,
    input logic [RANGE_W-1:0]        first,
    input logic [RANGE_W-1:0]        past_end
  );
    search_outcome_t outcome;
    int              lo;
    int              hi;
    int              mid;
    outcome = '0;
    lo = (first > TABLE_DEPTH) ? TABLE_DEPTH : int'(first);
    hi = (past_end > TABLE_DEPTH) ? TABLE_DEPTH : int'(past_end);
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (entry_copy[mid] == target) begin
        outcome.found    = 1'b1;
        outcome.position = POS_W'(mid);
        return outcome;
      end else if (entry_copy[mid] < target) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    return outcome;
  endfunction

  always @(posedge clk) begin : watch
    search_outcome_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (awaited_outcomes.size() == 0) begin
          $display("%0t: result with no search awaiting it: found %0b position %0d",
                   $time, out_found, out_position);
          mismatches++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (out_found !== want.found) begin
            $display("%0t: found expected %0b got %0b", $time, want.found, out_found);
            mismatches++;
          end
          if (out_position !== want.position) begin
            $display("%0t: position expected %0d got %0d",
                     $time, want.position, out_position);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        if (in_op == OP_WRITE) begin
          if (in_entry_index < TABLE_DEPTH) entry_copy[in_entry_index] = in_value;
        end else begin
          awaited_outcomes.push_back(search_table(in_value, in_range_low, in_range_high));
        end
      end
    end
    awaited_count = awaited_outcomes.size();
  end

endmodule

@@ sim/sorted_table_binary_search_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_tb
// Drives the sorted table search block with a short directed sequence
// (empty and inverted ranges, ranges past the table end, extreme values,
// duplicates, an unsorted stretch) followed by random rounds that fill runs
// of the table, mostly ascending, and search mostly within written runs.
// A separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_tb;
  import stbs_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int ITEM_TARGET = 1300;
  localparam int QUIET_FROM  = 1150;
  localparam int RANGE_MAX   = (1 << RANGE_W) - 1;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [OP_W-1:0]           in_op;
  logic [IDX_W-1:0]          in_entry_index;
  logic signed [VALUE_W-1:0] in_value;
  logic [RANGE_W-1:0]        in_range_low;
  logic [RANGE_W-1:0]        in_range_high;
  logic                      out_valid;
  logic                      out_found;
  logic [POS_W-1:0]          out_position;
  int                        fail_count;
  int                        outstanding;

  logic signed [VALUE_W-1:0] shadow [DEPTH];
  bit                        written [DEPTH];
  int                        writes_sent = 0;
  int                        searches_sent = 0;
  int                        empty_searches = 0;
  int                        idle_mode = 0;
  bit                        drained_mid = 1'b0;

  always #10 clk = ~clk;

  sorted_table_binary_search #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_entry_index(in_entry_index),
    .in_value      (in_value),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .out_valid     (out_valid),
    .out_found     (out_found),
    .out_position  (out_position)
  );

  sorted_table_binary_search_checker #(
    .TABLE_DEPTH(DEPTH)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_entry_index(in_entry_index),
    .in_value      (in_value),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .out_valid     (out_valid),
    .out_found     (out_found),
    .out_position  (out_position),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  task automatic send_item(
    input logic [OP_W-1:0]           op,
    input logic [IDX_W-1:0]          idx,
    input logic signed [VALUE_W-1:0] val,
    input logic [RANGE_W-1:0]        lo,
    input logic [RANGE_W-1:0]        hi
  );
    @(negedge clk);
    start          <= 1'b1;
    in_op          <= op;
    in_entry_index <= idx;
    in_value       <= val;
    in_range_low   <= lo;
    in_range_high  <= hi;
    do @(posedge clk); while (busy);
    if (op == OP_WRITE) begin
      shadow[idx]  = val;
      written[idx] = 1'b1;
      writes_sent++;
    end else begin
      searches_sent++;
    end
  endtask

  task automatic write_entry(input int idx, input logic signed [VALUE_W-1:0] val);
    send_item(OP_WRITE, IDX_W'(idx), val, RANGE_W'($urandom()), RANGE_W'($urandom()));
  endtask

  task automatic search_range(input logic signed [VALUE_W-1:0] target, input int lo,
                              input int hi);
    if ((lo > DEPTH ? DEPTH : lo) >= (hi > DEPTH ? DEPTH : hi)) empty_searches++;
    send_item(OP_SEARCH, IDX_W'($urandom()), target, RANGE_W'(lo), RANGE_W'(hi));
  endtask

  task automatic hold_off(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic pause_sender();
    if (writes_sent + searches_sent < QUIET_FROM && idle_mode != 0 &&
        $urandom_range(0, idle_mode == 1 ? 5 : 1) == 0)
      hold_off($urandom_range(1, 13));
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_run();
    int     first;
    int     len;
    int     k;
    bit     scrambled;
    longint level;
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
    first = ($urandom_range(0, 9) == 0) ? DEPTH - len : $urandom_range(0, DEPTH - 1);
    if (first + len > DEPTH) len = DEPTH - first;
    scrambled = ($urandom_range(0, 6) == 0);
    level = longint'($signed($urandom()));
    for (k = 0; k < len; k++) begin
      pause_sender();
      if (scrambled) write_entry(first + k, $urandom());
      else write_entry(first + k, level[VALUE_W-1:0]);
      level += $urandom_range(0, 1 << $urandom_range(0, 20));
      if (level > 64'sd2147483647) level = 64'sd2147483647;
    end
  endtask

  task automatic random_search();
    int                        lo;
    int                        hi;
    int                        run_end;
    int                        tries;
    int                        pick;
    int                        sel;
    logic signed [VALUE_W-1:0] target;
    lo = -1;
    if ($urandom_range(0, 9) != 0) begin
      for (tries = 0; tries < 32 && lo < 0; tries++) begin
        pick = $urandom_range(0, DEPTH - 1);
        if (written[pick]) lo = pick;
      end
    end
    if (lo < 0) begin
      hi = $urandom_range(0, RANGE_MAX);
      lo = $urandom_range(hi, RANGE_MAX);
      search_range($urandom(), lo, hi);
      return;
    end
    run_end = lo;
    while (run_end < DEPTH && written[run_end]) run_end++;
    hi = $urandom_range(lo + 1, run_end);
    pick = $urandom_range(lo, hi - 1);
    if (run_end == DEPTH && $urandom_range(0, 3) == 0) hi = $urandom_range(DEPTH + 1, RANGE_MAX);
    sel = $urandom_range(0, 9);
    if (sel < 5) target = shadow[pick];
    else if (sel < 7) target = shadow[pick] + ($urandom_range(0, 1) ? 1 : -1);
    else target = $urandom();
    search_range(target, lo, hi);
  endtask

  initial begin
    #(20_000_000);
    $display("Timed out waiting for the block");
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_op          = OP_WRITE;
    in_entry_index = '0;
    in_value       = '0;
    in_range_low   = '0;
    in_range_high  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    search_range(0, 0, 0);
    search_range(-1, 5, 3);
    search_range(32'sh7FFF_FFFF, RANGE_MAX, RANGE_MAX);
    search_range(0, DEPTH, RANGE_MAX);
    search_range(0, 1500, DEPTH);
    write_entry(0, -100);
    write_entry(1, -5);
    write_entry(2, 0);
    write_entry(3, 7);
    write_entry(4, 7);
    write_entry(5, 1000);
    write_entry(DEPTH - 2, 32'sh8000_0000);
    write_entry(DEPTH - 1, 32'sh7FFF_FFFF);
    write_entry(10, 50);
    write_entry(11, 40);
    write_entry(12, 30);
    search_range(7, 0, 6);
    search_range(-100, 0, 6);
    search_range(1000, 0, 6);
    search_range(6, 0, 6);
    search_range(32'sh8000_0000, DEPTH - 2, RANGE_MAX);
    search_range(32'sh7FFF_FFFF, DEPTH - 1, DEPTH);
    search_range(0, DEPTH - 2, DEPTH);
    search_range(30, 10, 13);
    drain();

    while (writes_sent + searches_sent < ITEM_TARGET) begin
      idle_mode = $urandom_range(0, 2);
      write_run();
      repeat ($urandom_range(2, 12)) begin
        pause_sender();
        random_search();
      end
      if (!drained_mid && writes_sent + searches_sent >= ITEM_TARGET / 2) begin
        drain();
        drained_mid = 1'b1;
      end
    end

    drain();
    repeat (40) @(negedge clk);
    $display("Sent %0d table writes and %0d searches, %0d of them over an empty range.",
             writes_sent, searches_sent, empty_searches);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
